// ===== hw/rtl/vps_pkg.sv =====
// vps_pkg: shared types, codes and the microprogram of the velocity profile sequencer
// no dependencies; imported by velocity_profile_sequencer
package vps_pkg;

  localparam int unsigned STREAM_DEPTH_DEF  = 64;
  localparam int unsigned VELOCITY_BITS_DEF = 16;

  // stream codes, also the phase field of a result
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_RUN   = 2'd2,
    PH_STOP  = 2'd3
  } phase_t;

  // input transaction kinds, carried on in_tuser
  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_START = 2'd1,
    KIND_STOP  = 2'd2,
    KIND_WRITE = 2'd3
  } kind_t;

  // configuration register indexes
  localparam logic [2:0] CFG_FRAME_DELAY = 3'd0;
  localparam logic [2:0] CFG_IDLE_LEN    = 3'd1;
  localparam logic [2:0] CFG_START_LEN   = 3'd2;
  localparam logic [2:0] CFG_RUN_LEN     = 3'd3;
  localparam logic [2:0] CFG_STOP_LEN    = 3'd4;

  typedef logic [3:0] step_t;

  // microprogram addresses; the four dispatch targets follow the kind codes
  localparam step_t ST_FETCH   = 4'd0;
  localparam step_t ST_TICK    = 4'd1;
  localparam step_t ST_START   = 4'd2;
  localparam step_t ST_STOP    = 4'd3;
  localparam step_t ST_WRITE   = 4'd4;
  localparam step_t ST_CHAIN   = 4'd5;
  localparam step_t ST_TREAD   = 4'd6;
  localparam step_t ST_EMIT    = 4'd7;
  localparam step_t ST_S_RD    = 4'd8;
  localparam step_t ST_S_SCAN  = 4'd9;
  localparam step_t ST_P_RD    = 4'd10;
  localparam step_t ST_P_SCAN  = 4'd11;

  typedef enum logic [3:0] {
    OP_FETCH,
    OP_PRESC,
    OP_START_SEL,
    OP_STOP_SEL,
    OP_WRITE,
    OP_CHAIN,
    OP_TREAD,
    OP_EMIT,
    OP_SCAN_RD,
    OP_SCAN_UP,
    OP_SCAN_DN
  } op_t;

  // jump condition of a control word
  typedef enum logic [1:0] {
    C_ALWAYS,
    C_DISPATCH,
    C_OUT,
    C_FLAG
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t jmp;
    step_t nxt;
  } ctrl_word_t;

  function automatic ctrl_word_t ucode_rom(input step_t s);
    ctrl_word_t w;
    w = '{op: OP_FETCH, cond: C_DISPATCH, jmp: ST_TICK, nxt: ST_FETCH};
    case (s)
      ST_FETCH:  w = '{op: OP_FETCH,     cond: C_DISPATCH, jmp: ST_TICK,   nxt: ST_FETCH};
      ST_TICK:   w = '{op: OP_PRESC,     cond: C_FLAG,     jmp: ST_CHAIN,  nxt: ST_TREAD};
      ST_START:  w = '{op: OP_START_SEL, cond: C_FLAG,     jmp: ST_S_RD,   nxt: ST_FETCH};
      ST_STOP:   w = '{op: OP_STOP_SEL,  cond: C_FLAG,     jmp: ST_P_RD,   nxt: ST_FETCH};
      ST_WRITE:  w = '{op: OP_WRITE,     cond: C_ALWAYS,   jmp: ST_FETCH,  nxt: ST_FETCH};
      ST_CHAIN:  w = '{op: OP_CHAIN,     cond: C_FLAG,     jmp: ST_TREAD,  nxt: ST_CHAIN};
      ST_TREAD:  w = '{op: OP_TREAD,     cond: C_ALWAYS,   jmp: ST_EMIT,   nxt: ST_EMIT};
      ST_EMIT:   w = '{op: OP_EMIT,      cond: C_OUT,      jmp: ST_FETCH,  nxt: ST_EMIT};
      ST_S_RD:   w = '{op: OP_SCAN_RD,   cond: C_ALWAYS,   jmp: ST_S_SCAN, nxt: ST_S_SCAN};
      ST_S_SCAN: w = '{op: OP_SCAN_UP,   cond: C_FLAG,     jmp: ST_S_SCAN, nxt: ST_FETCH};
      ST_P_RD:   w = '{op: OP_SCAN_RD,   cond: C_ALWAYS,   jmp: ST_P_SCAN, nxt: ST_P_SCAN};
      ST_P_SCAN: w = '{op: OP_SCAN_DN,   cond: C_FLAG,     jmp: ST_P_SCAN, nxt: ST_FETCH};
      default:   w = '{op: OP_FETCH,     cond: C_DISPATCH, jmp: ST_TICK,   nxt: ST_FETCH};
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/velocity_profile_sequencer.sv =====
// velocity_profile_sequencer: microcoded player of four stored velocity streams
// depends on vps_pkg (types, codes, microprogram rom)
//
// usage:
//   in_*  : one transaction per command; in_tuser holds the kind (tick, start,
//           stop, table write), in_tdata the request flags and table entry.
//   out_* : one result per tick transaction (velocity, phase); start, stop and
//           write transactions give none.
//   cfg_* : register writes (frame delay, four stream lengths), to be made while idle; the block does not enforce it.
// timing: in_tready is high only while the sequencer sits in its fetch step.
//   tick: prescale step, then the chain step when the frame step ends (repeated for
//         each stream change at a stream end), then table read and emit; the result
//         waits in the output register while the next transaction is fetched.
//   start/stop/write: a select or write step; a smooth scan adds a read step, then
//         scan steps over the entries passed, bounded by the stream length.
//   the registered read port of the profile table sets the scan rate.
// reset: stream idle, position, prescaler and last velocity cleared, frame delay
//   1 and all lengths 0; table contents are undefined until written.
// stall: a tick waits in its emit step while the output register is full.
module velocity_profile_sequencer
  import vps_pkg::*;
#(
  parameter int unsigned STREAM_DEPTH  = STREAM_DEPTH_DEF,
  parameter int unsigned VELOCITY_BITS = VELOCITY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [0] force_req, [1] smooth, [3:2] stream_select, [9:4] entry_index, [25:10] entry_value
  input  logic [31:0] in_tdata,
  // [1:0] kind
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] velocity, [17:16] phase
  output logic [23:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  localparam int unsigned POS_W     = $clog2(STREAM_DEPTH + 1);
  localparam int unsigned IDX_W     = (STREAM_DEPTH > 1) ? $clog2(STREAM_DEPTH) : 1;
  localparam int unsigned ADDR_W    = IDX_W + 2;
  localparam int unsigned MEM_DEPTH = 4 << IDX_W;
  localparam int unsigned VB        = VELOCITY_BITS;

  // configuration
  logic [7:0] frame_delay_r;
  logic [6:0] len_r [4];
  logic [POS_W-1:0] len_eff [4];

  // sequencer
  step_t      step_r, step_nxt;
  ctrl_word_t cw;
  logic       flag;
  logic       take;

  // architectural state
  phase_t               cur_r, cur_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [7:0]           presc_r, presc_nxt;
  logic signed [VB-1:0] last_r, last_nxt;
  logic                 hit_r, hit_nxt;

  // latched request
  logic                 force_r;
  logic                 smooth_r;
  logic [1:0]           sel_r;
  logic [5:0]           idx_r;
  logic signed [15:0]   value_r;

  // table
  logic signed [VB-1:0] mem [MEM_DEPTH];
  logic signed [VB-1:0] rd_r;
  logic [ADDR_W-1:0]    raddr;
  logic [ADDR_W-1:0]    waddr;
  logic                 mem_we;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_vel_r, out_vel_nxt;
  logic [1:0]  out_phase_r, out_phase_nxt;

  logic             in_fire;
  logic             out_free;
  logic [7:0]       presc_inc;
  logic             frame_done;
  logic [POS_W-1:0] cur_len;
  logic [POS_W-1:0] pos_inc;
  logic             pos_in;
  logic             inc_in;
  logic             run_busy;
  logic             stop_busy;
  logic             start_ok;
  logic             stop_ok;

  assign in_tready  = (step_r == ST_FETCH);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_phase_r, out_vel_r};

  // saturate lengths at the stream depth
  always_comb begin
    for (int s = 0; s < 4; s++) begin
      len_eff[s] = (32'(len_r[s]) > 32'(STREAM_DEPTH)) ? POS_W'(STREAM_DEPTH)
                                                         : POS_W'(len_r[s]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_delay_r <= 8'd1;
      for (int s = 0; s < 4; s++) len_r[s] <= 7'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_DELAY: frame_delay_r <= cfg_wdata;
        CFG_IDLE_LEN:    len_r[0] <= cfg_wdata[6:0];
        CFG_START_LEN:   len_r[1] <= cfg_wdata[6:0];
        CFG_RUN_LEN:     len_r[2] <= cfg_wdata[6:0];
        CFG_STOP_LEN:    len_r[3] <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  assign cw         = ucode_rom(step_r);
  assign presc_inc  = presc_r + 8'd1;
  assign frame_done = (presc_inc >= frame_delay_r);
  assign cur_len    = len_eff[cur_r];
  assign pos_inc    = pos_r + POS_W'(1);
  assign pos_in     = (pos_r < cur_len);
  assign inc_in     = (pos_inc < cur_len);
  assign run_busy   = (cur_r == PH_START) || (cur_r == PH_RUN);
  assign stop_busy  = (cur_r == PH_STOP) || (cur_r == PH_IDLE);
  assign start_ok   = (len_eff[PH_START] != '0) || (len_eff[PH_RUN] != '0);
  assign stop_ok    = (len_eff[PH_STOP] != '0) || (len_eff[PH_IDLE] != '0);

  // branch condition from the datapath
  always_comb begin
    unique case (cw.op)
      OP_PRESC:     flag = frame_done;
      OP_START_SEL: flag = !force_r && smooth_r && !run_busy && start_ok;
      OP_STOP_SEL:  flag = !force_r && smooth_r && !stop_busy && stop_ok;
      OP_CHAIN:     flag = pos_in || (cur_r == PH_IDLE)
                           || ((cur_r == PH_RUN) && (len_eff[PH_RUN] != '0));
      OP_SCAN_UP:   flag = (last_r > rd_r) && inc_in;
      OP_SCAN_DN:   flag = (last_r < rd_r) && inc_in;
      default:      flag = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    unique case (cw.cond)
      C_ALWAYS:   take = 1'b1;
      C_DISPATCH: take = in_fire;
      C_OUT:      take = out_free;
      C_FLAG:     take = flag;
    endcase
    if (!take) begin
      step_nxt = cw.nxt;
    end else if (cw.cond == C_DISPATCH) begin
      step_nxt = cw.jmp + step_t'(in_tuser);
    end else begin
      step_nxt = cw.jmp;
    end
  end

  // datapath actions of the control word
  always_comb begin
    cur_nxt       = cur_r;
    pos_nxt       = pos_r;
    presc_nxt     = presc_r;
    last_nxt      = last_r;
    hit_nxt       = hit_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_vel_nxt   = out_vel_r;
    out_phase_nxt = out_phase_r;
    mem_we        = 1'b0;
    unique case (cw.op)
      OP_PRESC: begin
        if (frame_done) begin
          presc_nxt = 8'd0;
          pos_nxt   = pos_inc;
        end else begin
          presc_nxt = presc_inc;
        end
      end
      OP_CHAIN: begin
        if (!pos_in) begin
          pos_nxt = '0;
          unique case (cur_r)
            PH_IDLE:  cur_nxt = PH_IDLE;
            PH_START: cur_nxt = PH_RUN;
            PH_RUN:   cur_nxt = (len_eff[PH_RUN] != '0) ? PH_RUN : PH_STOP;
            PH_STOP:  cur_nxt = PH_IDLE;
          endcase
        end
      end
      OP_TREAD: hit_nxt = pos_in;
      OP_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_vel_nxt   = hit_r ? 16'(rd_r) : 16'd0;
          out_phase_nxt = cur_r;
          if (hit_r) last_nxt = rd_r;
        end
      end
      OP_START_SEL: begin
        if (force_r) begin
          cur_nxt   = PH_START;
          pos_nxt   = '0;
          presc_nxt = 8'd0;
        end else if (!run_busy && start_ok) begin
          cur_nxt   = (len_eff[PH_START] != '0) ? PH_START : PH_RUN;
          pos_nxt   = '0;
          presc_nxt = 8'd0;
        end
      end
      OP_STOP_SEL: begin
        if (force_r) begin
          cur_nxt   = PH_IDLE;
          pos_nxt   = '0;
          presc_nxt = 8'd0;
          last_nxt  = '0;
        end else if (!stop_busy && stop_ok) begin
          cur_nxt   = (len_eff[PH_STOP] != '0) ? PH_STOP : PH_IDLE;
          pos_nxt   = '0;
          presc_nxt = 8'd0;
        end
      end
      OP_SCAN_UP: begin
        if (last_r > rd_r) begin
          if (inc_in) begin
            pos_nxt = pos_inc;
          end else begin
            // ran off the end: go on to the run stream, else the stop stream if non-empty, else idle
            pos_nxt = '0;
            if (len_eff[PH_RUN] != '0)       cur_nxt = PH_RUN;
            else if (len_eff[PH_STOP] != '0) cur_nxt = PH_STOP;
            else                             cur_nxt = PH_IDLE;
          end
        end
      end
      OP_SCAN_DN: begin
        if (last_r < rd_r) begin
          if (inc_in) begin
            pos_nxt = pos_inc;
          end else begin
            pos_nxt = '0;
            cur_nxt = PH_IDLE;
          end
        end
      end
      OP_WRITE: mem_we = (32'(idx_r) < 32'(STREAM_DEPTH));
      default: ;
    endcase
  end

  // the scan steps fetch one entry ahead so each cycle compares one entry
  assign raddr = ((cw.op == OP_SCAN_UP) || (cw.op == OP_SCAN_DN))
                 ? {cur_r, IDX_W'(pos_inc)} : {cur_r, IDX_W'(pos_r)};
  assign waddr = {sel_r, IDX_W'(idx_r)};

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= VB'(value_r);
    rd_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      force_r  <= in_tdata[0];
      smooth_r <= in_tdata[1];
      sel_r    <= in_tdata[3:2];
      idx_r    <= in_tdata[9:4];
      value_r  <= in_tdata[25:10];
    end
    out_vel_r   <= out_vel_nxt;
    out_phase_r <= out_phase_nxt;
    hit_r       <= hit_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ST_FETCH;
      cur_r       <= PH_IDLE;
      pos_r       <= '0;
      presc_r     <= 8'd0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      cur_r       <= cur_nxt;
      pos_r       <= pos_nxt;
      presc_r     <= presc_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
